// ----- src/playfair_digraph_cipher_macros.svh -----
// Assertion macros for the Playfair digraph cipher block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
`define PLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define PLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define PLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/plf_pkg.sv -----
// Shared types, constants and helper functions for the Playfair digraph cipher.
// Used by the interfaces and by every module of the block.
`default_nettype none

package plf_pkg;

    localparam int LETTER_W        = 5;
    localparam int CELL_W          = 5;
    localparam int GRID_W          = 3;
    localparam int KEY_W           = 60;
    localparam int CELLS           = 25;
    localparam int LETTERS         = 26;
    localparam int MAX_KEY_LETTERS_DEF = 24;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] MAX_CODE = 5'd25;
    localparam logic [GRID_W-1:0]   GRID_LAST = 3'd4;

    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_Z        = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_DECRYPT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
    } t_pos;

    typedef struct packed {
        logic                en;
        logic [CELL_W-1:0]   tab_idx;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] slot;
        t_pos                pos;
    } t_tbl_wr;

    typedef struct packed {
        logic [LETTER_W-1:0] pos_addr0;
        logic [LETTER_W-1:0] pos_addr1;
        logic [CELL_W-1:0]   tab_addr0;
        logic [CELL_W-1:0]   tab_addr1;
    } t_tbl_rd;

    function automatic logic [LETTER_W-1:0] merge_ij(input logic [LETTER_W-1:0] c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    function automatic logic [GRID_W-1:0] grid_step(input logic [GRID_W-1:0] v,
                                                    input logic back);
        logic [GRID_W-1:0] r;
        if (back) begin
            r = (v == '0) ? GRID_LAST : v - 3'd1;
        end else begin
            r = (v == GRID_LAST) ? '0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [GRID_W-1:0] row,
                                                  input logic [GRID_W-1:0] col);
        return {row[2:0], 2'b00} + CELL_W'(row) + CELL_W'(col);
    endfunction

endpackage

`default_nettype wire

// ----- src/plf_ifs.sv -----
// Valid/ready channel interfaces for text items, result items and configuration writes.
// Depends on plf_pkg for field widths.
`default_nettype none

interface plf_in_if import plf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;
    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface plf_out_if import plf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

interface plf_cfg_if import plf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [KEY_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/plf_tables.sv -----
// Key table memory (cell to letter) and position memory (letter to row and column).
// Depends on plf_pkg; both memories have one write port and two registered read ports.
`default_nettype none

module plf_tables import plf_pkg::*; (
    input  wire logic                i_clk,
    input  wire t_tbl_wr             i_wr,
    input  wire t_tbl_rd             i_rd,
    output t_pos                     o_pos0,
    output t_pos                     o_pos1,
    output logic [LETTER_W-1:0]      o_tab0,
    output logic [LETTER_W-1:0]      o_tab1
);

    logic [LETTER_W-1:0] r_tab_mem [CELLS];
    t_pos                r_pos_mem [LETTERS];
    t_pos                r_pos0;
    t_pos                r_pos1;
    logic [LETTER_W-1:0] r_tab0;
    logic [LETTER_W-1:0] r_tab1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tab_mem[i_wr.tab_idx] <= i_wr.letter;
            r_pos_mem[i_wr.slot] <= i_wr.pos;
        end
        r_tab0 <= r_tab_mem[i_rd.tab_addr0];
        r_tab1 <= r_tab_mem[i_rd.tab_addr1];
        r_pos0 <= r_pos_mem[i_rd.pos_addr0];
        r_pos1 <= r_pos_mem[i_rd.pos_addr1];
    end

    assign o_pos0 = r_pos0;
    assign o_pos1 = r_pos1;
    assign o_tab0 = r_tab0;
    assign o_tab1 = r_tab1;

endmodule

`default_nettype wire

// ----- src/plf_keybuild.sv -----
// Key table builder: walks the key letters, then the alphabet, one letter per cycle.
// Depends on plf_pkg; drives the write port of plf_tables.
`default_nettype none

module plf_keybuild import plf_pkg::*; #(
    parameter int MAX_KEY_LETTERS = MAX_KEY_LETTERS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_key_low,
    input  wire logic [KEY_W-1:0] i_key_high,
    input  wire logic [4:0]       i_key_len,
    output logic                  o_busy,
    output t_tbl_wr               o_wr
);

    `include "playfair_digraph_cipher_macros.svh"

    typedef enum logic [1:0] {B_IDLE, B_KEY, B_FILL} t_bphase;

    t_bphase             r_phase, n_phase;
    logic [4:0]          r_k, n_k;
    logic [4:0]          r_len, n_len;
    logic [4:0]          r_c, n_c;
    logic [CELL_W-1:0]   r_n, n_n;
    logic [GRID_W-1:0]   r_row, n_row;
    logic [GRID_W-1:0]   r_col, n_col;
    logic [LETTERS-1:0]  r_used, n_used;

    logic [2*KEY_W-1:0]  key_all;
    logic [6:0]          key_bit;
    logic [LETTER_W-1:0] key_c;
    logic [LETTER_W-1:0] cand;
    logic [LETTER_W-1:0] slot;
    logic                take;

    assign key_all = {i_key_high, i_key_low};
    assign key_bit = {r_k, 2'b00} + 7'(r_k);
    assign key_c   = key_all[key_bit +: LETTER_W];

    always_comb begin
        n_phase = r_phase;
        n_k     = r_k;
        n_len   = r_len;
        n_c     = r_c;
        n_n     = r_n;
        n_row   = r_row;
        n_col   = r_col;
        n_used  = r_used;
        cand    = r_c;
        slot    = merge_ij(r_c);
        take    = 1'b0;
        unique case (r_phase)
            B_IDLE: begin
                if (i_start) begin
                    n_phase = B_KEY;
                    n_k     = '0;
                    n_n     = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_used  = '0;
                    n_len   = (i_key_len > 5'(MAX_KEY_LETTERS)) ? 5'(MAX_KEY_LETTERS)
                                                                : i_key_len;
                end
            end
            B_KEY: begin
                if (r_k == r_len) begin
                    n_phase = B_FILL;
                    n_c     = '0;
                end else begin
                    cand = key_c;
                    slot = merge_ij(key_c);
                    take = (cand <= MAX_CODE && r_n < CELL_W'(CELLS)) ? !r_used[slot]
                                                                       : 1'b0;
                    n_k  = r_k + 5'd1;
                end
            end
            B_FILL: begin
                if (r_n == CELL_W'(CELLS) || r_c == 5'(LETTERS)) begin
                    n_phase = B_IDLE;
                end else begin
                    take = !r_used[slot];
                    n_c  = r_c + 5'd1;
                end
            end
            default: n_phase = B_IDLE;
        endcase
        if (take) begin
            n_used[slot] = 1'b1;
            n_n          = r_n + 5'd1;
            if (r_col == GRID_LAST) begin
                n_col = '0;
                n_row = r_row + 3'd1;
            end else begin
                n_col = r_col + 3'd1;
            end
        end
    end

    always_comb begin
        o_wr.en      = take;
        o_wr.tab_idx = r_n;
        o_wr.letter  = cand;
        o_wr.slot    = slot;
        o_wr.pos     = '{row: r_row, col: r_col};
    end

    assign o_busy = (r_phase != B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= B_IDLE;
            r_k     <= '0;
            r_len   <= '0;
            r_c     <= '0;
            r_n     <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_used  <= '0;
        end else begin
            r_phase <= n_phase;
            r_k     <= n_k;
            r_len   <= n_len;
            r_c     <= n_c;
            r_n     <= n_n;
            r_row   <= n_row;
            r_col   <= n_col;
            r_used  <= n_used;
        end
    end

    `PLF_ASSERT_IMPL(a_no_j_slot, i_clk, i_rst_n, o_wr.en, o_wr.slot != LETTER_J)
    `PLF_ASSERT_IMPL(a_key_fits, i_clk, i_rst_n, r_phase == B_KEY, r_n < CELL_W'(CELLS))
    `PLF_ASSERT_NEXT(a_full_ends, i_clk, i_rst_n, r_phase == B_FILL && r_n == CELL_W'(CELLS), r_phase == B_IDLE)

endmodule

`default_nettype wire

// ----- src/plf_text.sv -----
// Text sequencer: case folding, pass-through, pairing and digraph rules, result buffer.
// Depends on plf_pkg, the channel interfaces and the read ports of plf_tables.
`default_nettype none

module plf_text import plf_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    plf_in_if.sink                   i_in,
    plf_out_if.source                o_out,
    input  wire logic                i_decrypt,
    input  wire logic                i_build_busy,
    input  wire t_pos                i_pos0,
    input  wire t_pos                i_pos1,
    input  wire logic [LETTER_W-1:0] i_tab0,
    input  wire logic [LETTER_W-1:0] i_tab1,
    output logic                     o_build_start,
    output t_tbl_rd                  o_rd
);

    `include "playfair_digraph_cipher_macros.svh"

    typedef enum logic [2:0] {T_IDLE, T_BUILD, T_POS, T_TAB} t_tstate;

    t_tstate             r_state, n_state;
    logic                r_pending, n_pending;
    logic [LETTER_W-1:0] r_held, n_held;
    logic [1:0]          r_out_cnt, n_out_cnt;
    logic [7:0]          r_q_char [2];
    logic [7:0]          n_q_char [2];
    logic                r_q_last [2];
    logic                n_q_last [2];

    logic                acc;
    logic                pop;
    logic [7:0]          up;
    logic                is_letter;
    logic [LETTER_W-1:0] code;
    logic [GRID_W-1:0]   or0, oc0, or1, oc1;

    assign i_in.ready = (r_state == T_IDLE) && (r_out_cnt == 2'd0);
    assign acc        = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    assign up = (i_in.text_byte >= CH_LOWER_A && i_in.text_byte <= CH_LOWER_Z)
              ? i_in.text_byte - CASE_OFFSET : i_in.text_byte;
    assign is_letter = (up >= CH_A) && (up <= CH_Z);
    assign code      = LETTER_W'(up - CH_A);

    always_comb begin
        if (i_pos0.col == i_pos1.col) begin
            or0 = grid_step(i_pos0.row, i_decrypt);
            or1 = grid_step(i_pos1.row, i_decrypt);
            oc0 = i_pos0.col;
            oc1 = i_pos1.col;
        end else if (i_pos0.row == i_pos1.row) begin
            or0 = i_pos0.row;
            or1 = i_pos1.row;
            oc0 = grid_step(i_pos0.col, i_decrypt);
            oc1 = grid_step(i_pos1.col, i_decrypt);
        end else begin
            or0 = i_pos0.row;
            or1 = i_pos1.row;
            oc0 = i_pos1.col;
            oc1 = i_pos0.col;
        end
    end

    always_comb begin
        o_rd.pos_addr0 = merge_ij(r_held);
        o_rd.pos_addr1 = merge_ij(code);
        o_rd.tab_addr0 = cell_of(or0, oc0);
        o_rd.tab_addr1 = cell_of(or1, oc1);
    end

    assign o_build_start     = acc && (i_in.kind == KIND_BUILD);
    assign o_out.valid       = (r_out_cnt != 2'd0);
    assign o_out.out_char    = r_q_char[0];
    assign o_out.last_of_run = r_q_last[0];

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_held    = r_held;
        n_out_cnt = r_out_cnt;
        n_q_char  = r_q_char;
        n_q_last  = r_q_last;
        if (pop) begin
            n_q_char[0] = r_q_char[1];
            n_q_last[0] = r_q_last[1];
            n_out_cnt   = r_out_cnt - 2'd1;
        end
        unique case (r_state)
            T_IDLE: begin
                if (acc) begin
                    if (i_in.kind == KIND_BUILD) begin
                        n_pending = 1'b0;
                        n_held    = '0;
                        n_state   = T_BUILD;
                    end else if (!is_letter) begin
                        n_q_char[0] = up;
                        n_q_last[0] = 1'b1;
                        n_out_cnt   = 2'd1;
                    end else if (!r_pending) begin
                        n_held    = code;
                        n_pending = 1'b1;
                    end else begin
                        n_pending = 1'b0;
                        n_state   = T_POS;
                    end
                end
            end
            T_BUILD: begin
                if (!i_build_busy) begin
                    n_state = T_IDLE;
                end
            end
            T_POS: begin
                n_state = T_TAB;
            end
            T_TAB: begin
                n_q_char[0] = 8'(i_tab0) + CH_A;
                n_q_last[0] = 1'b0;
                n_q_char[1] = 8'(i_tab1) + CH_A;
                n_q_last[1] = 1'b1;
                n_out_cnt   = 2'd2;
                n_state     = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_pending <= 1'b0;
            r_held    <= '0;
            r_out_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_held    <= n_held;
            r_out_cnt <= n_out_cnt;
        end
        r_q_char <= n_q_char;
        r_q_last <= n_q_last;
    end

    `PLF_ASSERT_NEXT(a_build_clears_pending, i_clk, i_rst_n, acc && i_in.kind == KIND_BUILD, !r_pending)
    `PLF_ASSERT_IMPL(a_pair_lands_empty, i_clk, i_rst_n, r_state == T_TAB, r_out_cnt == 2'd0)
    `PLF_ASSERT_IMPL(a_no_build_in_lookup, i_clk, i_rst_n, r_state == T_POS || r_state == T_TAB, !i_build_busy)
    `PLF_ASSERT_NEXT(a_pos_then_tab, i_clk, i_rst_n, r_state == T_POS, r_state == T_TAB)

endmodule

`default_nettype wire

// ----- src/playfair_digraph_cipher.sv -----
// Playfair digraph cipher. A non-letter item's result is registered and offered in the cycle
// after acceptance; the second letter of a pair gives two results, set by the position read,
// then the key table read and then the result buffer. A build item walks the key letters
// and then the alphabet, one letter per cycle in the builder. The next item is taken once the
// sequencer is idle and all results are delivered. Reset clears control state and the
// configuration registers; the key table is undefined until the first build item.
`default_nettype none

module playfair_digraph_cipher import plf_pkg::*; #(
    parameter int MAX_KEY_LETTERS = MAX_KEY_LETTERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plf_in_if.sink     i_in,
    plf_out_if.source  o_out,
    plf_cfg_if.sink    i_cfg
);

    logic [KEY_W-1:0]    r_key_low;
    logic [KEY_W-1:0]    r_key_high;
    logic [4:0]          r_key_len;
    logic                r_decrypt;

    logic                build_start;
    logic                build_busy;
    t_tbl_wr             tbl_wr;
    t_tbl_rd             tbl_rd;
    t_pos                pos0;
    t_pos                pos1;
    logic [LETTER_W-1:0] tab0;
    logic [LETTER_W-1:0] tab1;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_KEY_LOW:  r_key_low  <= i_cfg.data;
                CFG_KEY_HIGH: r_key_high <= i_cfg.data;
                CFG_KEY_LEN:  r_key_len  <= i_cfg.data[4:0];
                CFG_DECRYPT:  r_decrypt  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    plf_keybuild #(
        .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
    ) u_keybuild (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (build_start),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_key_len  (r_key_len),
        .o_busy     (build_busy),
        .o_wr       (tbl_wr)
    );

    plf_tables u_tables (
        .i_clk  (i_clk),
        .i_wr   (tbl_wr),
        .i_rd   (tbl_rd),
        .o_pos0 (pos0),
        .o_pos1 (pos1),
        .o_tab0 (tab0),
        .o_tab1 (tab1)
    );

    plf_text u_text (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_decrypt     (r_decrypt),
        .i_build_busy  (build_busy),
        .i_pos0        (pos0),
        .i_pos1        (pos1),
        .i_tab0        (tab0),
        .i_tab1        (tab1),
        .o_build_start (build_start),
        .o_rd          (tbl_rd)
    );

endmodule

`default_nettype wire
